/* hdl/cps_pkg.sv */
// Shared types, constants and helper functions of the clothoid path sampler.
// Used by the front, queue, engine and top-level modules; depends on nothing.
`default_nettype none

package cps_pkg;

  // Fixed point layout
  localparam int unsigned FRAC_BITS = 16;
  localparam logic [63:0] INV_TWO_PI_Q66 = 64'hA2F9836E4E44152A;
  // Radians-to-angle scale; fits in 30 bits at 16 fraction bits
  localparam logic [63:0] KQ_FULL =
    (INV_TWO_PI_Q66 + (64'd1 << (2 * FRAC_BITS + 1))) >> (2 * FRAC_BITS + 2);
  localparam logic [31:0] KQ = KQ_FULL[31:0];

  localparam logic [23:0] QUARTER_TURN = 24'h400000;
  localparam logic [47:0] ARC_MAX = 48'hFFFFFFFFFFFF;

  // Sine polynomial coefficients, Q30
  localparam logic signed [33:0] SIN_C1  = 34'sd1686629713;
  localparam logic signed [33:0] SIN_C3  = 34'sd693598668;
  localparam logic signed [33:0] SIN_C5  = 34'sd85569306;
  localparam logic signed [33:0] SIN_C7  = 34'sd5026995;
  localparam logic signed [33:0] SIN_C9  = 34'sd172272;
  localparam logic signed [33:0] SIN_C11 = 34'sd3864;

  // Register addresses (word index)
  localparam logic REG_SAMPLE_STEP = 1'b0;

  // One queued segment
  typedef struct packed {
    logic [47:0]        base;
    logic signed [31:0] x0;
    logic signed [31:0] y0;
    logic [23:0]        h0;
    logic signed [23:0] k0;
    logic signed [23:0] sig;
    logic [31:0]        len;
    logic               trunc;
  } seg_t;

  // One result sample
  typedef struct packed {
    logic [47:0] arc;
    logic [31:0] x;
    logic [31:0] y;
    logic [23:0] heading;
    logic [23:0] curv;
    logic        last;
    logic        trunc;
  } sample_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PICK, ST_SQ, ST_K0S, ST_QLO, ST_QHI, ST_KLO, ST_KHI,
    ST_CURV, ST_FOLD, ST_Z2, ST_POLY, ST_ZP, ST_X, ST_Y, ST_OUT
  } eng_state_e;

  // Horner coefficient for step idx, from the x^9 term down to x^1
  function automatic logic signed [33:0] sin_coef(input logic [2:0] idx);
    logic signed [33:0] c;
    unique case (idx)
      3'd0:    c = SIN_C9;
      3'd1:    c = SIN_C7;
      3'd2:    c = SIN_C5;
      3'd3:    c = SIN_C3;
      default: c = SIN_C1;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* hdl/cps_front.sv */
// Input side: unpacks segments, flags truncation and tracks path arclength.
// Depends on cps_pkg; pushes one seg_t per accepted item into the queue.
`default_nettype none

module cps_front #(
  parameter int unsigned MAX_SAMPLES = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // start_x, start_y, start_heading, start_curvature, curvature_rate, segment_length
  input  wire logic [167:0]         s_axis_tdata_i,
  // first_segment
  input  wire logic                 s_axis_tuser_i,
  input  wire logic [31:0]          sample_step_i,
  input  wire logic                 q_full_i,
  output logic                      q_push_o,
  output cps_pkg::seg_t             q_data_o
);

  localparam int unsigned LimW = $clog2(MAX_SAMPLES);
  localparam int unsigned ProdW = 32 + LimW;
  localparam logic [ProdW-1:0] Limit = ProdW'(MAX_SAMPLES - 1);

  logic [47:0] acc_q, acc_d;
  logic [47:0] base;
  logic [48:0] next_sum;
  logic [31:0] len;
  logic [ProdW-1:0] lim_span;
  logic trunc;
  logic accept;

  assign s_axis_tready_o = !q_full_i;
  assign accept = s_axis_tvalid_i && !q_full_i;
  assign len = s_axis_tdata_i[167:136];

  // Classify: interior samples beyond the limit mean truncation
  always_comb begin
    lim_span = ProdW'(sample_step_i) * Limit;
    if (len == 32'd0) begin
      trunc = 1'b0;
    end else if (sample_step_i == 32'd0) begin
      trunc = 1'b1;
    end else begin
      trunc = ProdW'(len) > lim_span;
    end
  end

  // Advance accumulated arclength, saturating
  always_comb begin
    base = s_axis_tuser_i ? 48'd0 : acc_q;
    next_sum = {1'b0, base} + {17'd0, len};
    acc_d = next_sum[48] ? cps_pkg::ARC_MAX : next_sum[47:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (accept) begin
      acc_q <= acc_d;
    end
  end

  // Pack queue entry
  always_comb begin
    q_push_o = accept;
    q_data_o.base  = base;
    q_data_o.x0    = s_axis_tdata_i[31:0];
    q_data_o.y0    = s_axis_tdata_i[63:32];
    q_data_o.h0    = s_axis_tdata_i[87:64];
    q_data_o.k0    = s_axis_tdata_i[111:88];
    q_data_o.sig   = s_axis_tdata_i[135:112];
    q_data_o.len   = len;
    q_data_o.trunc = trunc;
  end

endmodule

`default_nettype wire

/* hdl/cps_queue.sv */
// Two-entry queue of segments between the front and the sample engine.
// Depends on cps_pkg for the seg_t entry type.
`default_nettype none

module cps_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  cps_pkg::seg_t      data_i,
  output logic               full_o,
  output logic               valid_o,
  input  wire logic          pop_i,
  output cps_pkg::seg_t      data_o
);

  cps_pkg::seg_t mem_q [2];
  logic wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rptr_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/cps_engine.sv */
// Sample engine: steps each segment through its samples with one shared
// multiplier, and holds the result in an output register. Depends on cps_pkg.
`default_nettype none

module cps_engine #(
  parameter int unsigned MAX_SAMPLES = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [31:0]   sample_step_i,
  input  wire logic          q_valid_i,
  input  cps_pkg::seg_t      q_data_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output cps_pkg::sample_t   out_data_o
);

  localparam int unsigned NW = $clog2(MAX_SAMPLES);
  localparam logic [NW-1:0] Limit = NW'(MAX_SAMPLES - 1);
  localparam logic signed [24:0] Qtr = 25'sd4194304;
  localparam logic signed [24:0] Hlf = 25'sd8388608;
  localparam logic signed [67:0] I32Max = 68'sd2147483647;
  localparam logic signed [67:0] I32Min = -68'sd2147483648;
  localparam logic signed [67:0] I24Max = 68'sd8388607;
  localparam logic signed [67:0] I24Min = -68'sd8388608;

  cps_pkg::eng_state_e state_q, state_d;
  cps_pkg::seg_t seg_q;
  cps_pkg::sample_t out_q;

  logic [32:0] s_q;
  logic [NW-1:0] n_q;
  logic [31:0] samp_q;
  logic last_q;
  logic [63:0] ss_q, r_q;
  logic [31:0] hacc_q;
  logic [23:0] head_q, curv_q;
  logic signed [33:0] z_q, z2_q, p_q;
  logic [2:0] cidx_q;
  logic pass_q;
  logic signed [31:0] sin_q, cos_q, x_q, y_q;
  logic out_valid_q;

  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod, prod_sh, prod_f;
  logic signed [67:0] curv_sum, x_sum;
  logic interior, can_load, load_out;
  logic [31:0] khi_sum;
  logic [23:0] fold_in;
  logic signed [24:0] a25, fold;
  logic [48:0] arc_sum;

  assign prod    = mul_a * mul_b;
  assign prod_sh = prod >>> 30;
  assign prod_f  = prod >>> cps_pkg::FRAC_BITS;

  assign interior = ({1'b0, s_q} < {2'b0, seg_q.len}) && (n_q < Limit);
  assign can_load = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cps_pkg::ST_IDLE: if (q_valid_i) state_d = cps_pkg::ST_PICK;
      cps_pkg::ST_PICK: state_d = cps_pkg::ST_SQ;
      cps_pkg::ST_SQ:   state_d = cps_pkg::ST_K0S;
      cps_pkg::ST_K0S:  state_d = cps_pkg::ST_QLO;
      cps_pkg::ST_QLO:  state_d = cps_pkg::ST_QHI;
      cps_pkg::ST_QHI:  state_d = cps_pkg::ST_KLO;
      cps_pkg::ST_KLO:  state_d = cps_pkg::ST_KHI;
      cps_pkg::ST_KHI:  state_d = cps_pkg::ST_CURV;
      cps_pkg::ST_CURV: state_d = cps_pkg::ST_FOLD;
      cps_pkg::ST_FOLD: state_d = cps_pkg::ST_Z2;
      cps_pkg::ST_Z2:   state_d = cps_pkg::ST_POLY;
      cps_pkg::ST_POLY: if (cidx_q == 3'd4) state_d = cps_pkg::ST_ZP;
      cps_pkg::ST_ZP:   state_d = pass_q ? cps_pkg::ST_X : cps_pkg::ST_FOLD;
      cps_pkg::ST_X:    state_d = cps_pkg::ST_Y;
      cps_pkg::ST_Y:    state_d = cps_pkg::ST_OUT;
      cps_pkg::ST_OUT: begin
        if (can_load) begin
          state_d = last_q ? cps_pkg::ST_IDLE : cps_pkg::ST_PICK;
        end
      end
      default: state_d = cps_pkg::ST_IDLE;
    endcase
  end

  // Multiplier operands and handshake outputs
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    q_pop_o = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      cps_pkg::ST_IDLE: q_pop_o = q_valid_i;
      cps_pkg::ST_SQ: begin
        mul_a = {2'b0, samp_q};
        mul_b = {2'b0, samp_q};
      end
      cps_pkg::ST_K0S, cps_pkg::ST_CURV: begin
        mul_a = (state_q == cps_pkg::ST_K0S) ? {{10{seg_q.k0[23]}}, seg_q.k0}
                                              : {{10{seg_q.sig[23]}}, seg_q.sig};
        mul_b = {2'b0, samp_q};
      end
      cps_pkg::ST_QLO: begin
        mul_a = {{10{seg_q.sig[23]}}, seg_q.sig};
        mul_b = {2'b0, ss_q[48:17]};
      end
      cps_pkg::ST_QHI: begin
        mul_a = {{10{seg_q.sig[23]}}, seg_q.sig};
        mul_b = {19'b0, ss_q[63:49]};
      end
      cps_pkg::ST_KLO: begin
        mul_a = {2'b0, r_q[31:0]};
        mul_b = {2'b0, cps_pkg::KQ};
      end
      cps_pkg::ST_KHI: begin
        mul_a = {2'b0, r_q[63:32]};
        mul_b = {2'b0, cps_pkg::KQ};
      end
      cps_pkg::ST_Z2: begin
        mul_a = z_q;
        mul_b = z_q;
      end
      cps_pkg::ST_POLY: begin
        mul_a = z2_q;
        mul_b = p_q;
      end
      cps_pkg::ST_ZP: begin
        mul_a = z_q;
        mul_b = p_q;
      end
      cps_pkg::ST_X: begin
        mul_a = {2'b0, samp_q};
        mul_b = {{2{cos_q[31]}}, cos_q};
      end
      cps_pkg::ST_Y: begin
        mul_a = {2'b0, samp_q};
        mul_b = {{2{sin_q[31]}}, sin_q};
      end
      cps_pkg::ST_OUT: load_out = can_load;
      default: ;
    endcase
  end

  // Datapath helpers: heading update, angle fold, clamped sums
  always_comb begin
    khi_sum = hacc_q + prod[31:0];
    fold_in = pass_q ? (head_q + cps_pkg::QUARTER_TURN) : head_q;
    a25 = {fold_in[23], fold_in};
    if (a25 > Qtr) begin
      fold = Hlf - a25;
    end else if (a25 < -Qtr) begin
      fold = -Hlf - a25;
    end else begin
      fold = a25;
    end
    curv_sum = {{44{seg_q.k0[23]}}, seg_q.k0} + prod_f;
    x_sum = ((state_q == cps_pkg::ST_X) ? {{36{seg_q.x0[31]}}, seg_q.x0}
                                        : {{36{seg_q.y0[31]}}, seg_q.y0}) + prod_sh;
    arc_sum = {1'b0, seg_q.base} + {17'd0, samp_q};
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cps_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      cps_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          seg_q <= q_data_i;
          s_q <= '0;
          n_q <= '0;
        end
      end
      cps_pkg::ST_PICK: begin
        samp_q <= interior ? s_q[31:0] : seg_q.len;
        last_q <= !interior;
      end
      cps_pkg::ST_SQ:  ss_q <= prod[63:0];
      cps_pkg::ST_K0S: r_q <= prod[63:0];
      cps_pkg::ST_QLO: r_q <= r_q + prod[63:0];
      cps_pkg::ST_QHI: r_q <= r_q + {prod[31:0], 32'b0};
      cps_pkg::ST_KLO: hacc_q <= prod[63:32];
      cps_pkg::ST_KHI: head_q <= seg_q.h0 + khi_sum[31:8];
      cps_pkg::ST_CURV: begin
        if (curv_sum > I24Max) begin
          curv_q <= 24'h7FFFFF;
        end else if (curv_sum < I24Min) begin
          curv_q <= 24'h800000;
        end else begin
          curv_q <= curv_sum[23:0];
        end
        pass_q <= 1'b0;
      end
      cps_pkg::ST_FOLD: z_q <= {fold[24], fold, 8'b0};
      cps_pkg::ST_Z2: begin
        z2_q <= prod_sh[33:0];
        p_q <= cps_pkg::SIN_C11;
        cidx_q <= 3'd0;
      end
      cps_pkg::ST_POLY: begin
        p_q <= cps_pkg::sin_coef(cidx_q) - prod_sh[33:0];
        cidx_q <= cidx_q + 3'd1;
      end
      cps_pkg::ST_ZP: begin
        if (pass_q) begin
          cos_q <= prod_sh[31:0];
        end else begin
          sin_q <= prod_sh[31:0];
        end
        pass_q <= 1'b1;
      end
      cps_pkg::ST_X, cps_pkg::ST_Y: begin
        if (state_q == cps_pkg::ST_X) begin
          x_q <= (x_sum > I32Max) ? 32'h7FFFFFFF :
                 (x_sum < I32Min) ? 32'h80000000 : x_sum[31:0];
        end else begin
          y_q <= (x_sum > I32Max) ? 32'h7FFFFFFF :
                 (x_sum < I32Min) ? 32'h80000000 : x_sum[31:0];
        end
      end
      cps_pkg::ST_OUT: begin
        if (can_load && !last_q) begin
          n_q <= n_q + NW'(1);
          s_q <= s_q + {1'b0, sample_step_i};
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.arc     <= arc_sum[48] ? cps_pkg::ARC_MAX : arc_sum[47:0];
      out_q.x       <= x_q;
      out_q.y       <= y_q;
      out_q.heading <= head_q;
      out_q.curv    <= curv_q;
      out_q.last    <= last_q;
      out_q.trunc   <= seg_q.trunc;
    end
  end

endmodule

`default_nettype wire

/* hdl/clothoid_path_sampler_unit.sv */
// Clothoid path sampler: segment in, arclength/position/heading/curvature out.
// Segments wait in a two-entry queue while the engine steps each sample
// through its single shared multiplier; the next segment is taken only once
// the last sample of the current one is loaded into the output register.
// Reset clears the queue, the state machine and the accumulated arclength,
// and sets sample_step to 1.0.
`default_nettype none

module clothoid_path_sampler_unit #(
  parameter int unsigned MAX_SAMPLES = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  // start_x[31:0], start_y, start_heading, start_curvature, curvature_rate, segment_length
  input  wire logic [167:0]  s_axis_tdata_i,
  // first_segment
  input  wire logic          s_axis_tuser_i,
  output logic               m_axis_tvalid_o,
  input  wire logic          m_axis_tready_i,
  // path_arclength[47:0], sample_x, sample_y, sample_heading, sample_curvature
  output logic [159:0]       m_axis_tdata_o,
  output logic               m_axis_tlast_o,
  // truncated
  output logic               m_axis_tuser_o,
  input  wire logic          psel_i,
  input  wire logic          penable_i,
  input  wire logic          pwrite_i,
  input  wire logic [2:0]    paddr_i,
  input  wire logic [31:0]   pwdata_i,
  output logic [31:0]        prdata_o,
  output logic               pready_o
);

  logic [31:0] sample_step_q;
  logic q_full, q_push, q_valid, q_pop;
  cps_pkg::seg_t q_in, q_out;
  cps_pkg::sample_t res;

  // Configuration register
  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i[2] == cps_pkg::REG_SAMPLE_STEP) ? sample_step_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_step_q <= 32'd65536;
    end else if (psel_i && penable_i && pwrite_i &&
                 paddr_i[2] == cps_pkg::REG_SAMPLE_STEP) begin
      sample_step_q <= pwdata_i;
    end
  end

  cps_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tuser_i,
    .sample_step_i(sample_step_q),
    .q_full_i(q_full), .q_push_o(q_push), .q_data_o(q_in)
  );

  cps_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(q_push), .data_i(q_in), .full_o(q_full),
    .valid_o(q_valid), .pop_i(q_pop), .data_o(q_out)
  );

  cps_engine #(.MAX_SAMPLES(MAX_SAMPLES)) u_engine (
    .clk_i, .rst_ni,
    .sample_step_i(sample_step_q),
    .q_valid_i(q_valid), .q_data_i(q_out), .q_pop_o(q_pop),
    .out_valid_o(m_axis_tvalid_o), .out_ready_i(m_axis_tready_i),
    .out_data_o(res)
  );

  // Pack result stream
  assign m_axis_tdata_o = {res.curv, res.heading, res.y, res.x, res.arc};
  assign m_axis_tlast_o = res.last;
  assign m_axis_tuser_o = res.trunc;

endmodule

`default_nettype wire
